>>> rtl/fsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling-sand cell step package
// Grid sizes, cell, operation and result codes, and the sequencer states.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int GRID_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);

  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;
  localparam int RGB_W   = 24;

  typedef logic [1:0]         cell_t;
  typedef logic [1:0]         kind_t;
  typedef logic [1:0]         move_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [RGB_W-1:0]   rgb_t;

  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_SAND  = 2'd1;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_STEP  = 2'd2;

  localparam move_t MOVE_STAY  = 2'd0;
  localparam move_t MOVE_FALL  = 2'd1;
  localparam move_t MOVE_SLIDE = 2'd2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam size_t SIZE_RESET = 9'd256;

  localparam rgb_t SAND_RGB  = 24'hFFCC00;
  localparam rgb_t OTHER_RGB = 24'h6A0DAD;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_HERE,
    S_BELOW,
    S_SIDE,
    S_VACATE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ADDR_HERE,
    ADDR_BELOW,
    ADDR_SIDE
  } addr_sel_t;

  function automatic rgb_t type_rgb(input cell_t t);
    return (t == CELL_SAND) ? SAND_RGB : OTHER_RGB;
  endfunction

endpackage

>>> rtl/falling_sand_cell_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling-sand cell step core
// Grid of two-bit cells in one single-port memory, with write, read and
// sand-step operations run by a small sequencer around one address unit.
// ----------------------------------------------------------------------------
// Usage: an input word (kind, col, row, new_cell, go_right) is taken when
// in_valid is high and in_stall is low. One result word (cell_read, color,
// moved, coord_error) comes back on the output channel for every input word,
// held in an output register until out_stall is low. The config channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) writes grid_width (index 0)
// and grid_height (index 1); it is always ready.
//
// Memory and flow: every grid access goes through the single memory port
// with a registered read, one access per cycle. One word is worked on at a
// time; the input stalls until the cycle after the result is loaded. A
// finished result may wait in the output register while the next word is
// accepted; the sequencer holds in its last state if the receiver still
// stalls the earlier result when the next one is ready.
//
// Reset: rst clears the sequencer, sets both sizes to 256 and starts a
// clearing pass that writes every grid cell to empty, one cell a cycle,
// over all GRID_DEPTH (65536) cells. in_stall is high throughout the pass.
// ----------------------------------------------------------------------------
module falling_sand_cell_step_core
  import fsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  kind_t       kind,
  input  coord_t      col,
  input  coord_t      row,
  input  cell_t       new_cell,
  input  logic        go_right,

  output logic        out_valid,
  input  logic        out_stall,
  output cell_t       cell_read,
  output rgb_t        color,
  output move_t       moved,
  output logic        coord_error,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  size_t       cfg_data
);

  // Sequencer state and the clearing counter.
  state_t state;
  state_t state_next;
  addr_t  clr_addr;

  // Registered copy of the word being worked on.
  kind_t  op_kind;
  coord_t op_col;
  coord_t op_row;
  cell_t  op_new;
  logic   op_right;

  // Working result.
  cell_t  old_cell;
  cell_t  old_cell_next;
  move_t  move_code;
  move_t  move_code_next;
  logic   err_flag;
  logic   err_flag_next;

  // Size registers as written, and their clamped values.
  size_t  grid_width;
  size_t  grid_height;
  size_t  w_eff;
  size_t  h_eff;

  // Memory port.
  cell_t     grid_mem [GRID_DEPTH];
  cell_t     rd_data;
  addr_t     mem_addr;
  addr_t     gen_addr;
  logic      mem_we;
  cell_t     mem_wdata;
  addr_sel_t addr_sel;
  logic      clearing;

  logic      capture_in;
  logic      load_out;

  // Neighbor coordinates and their checks.
  coord_t    row_below;
  coord_t    col_side;
  coord_t    sel_row;
  coord_t    sel_col;
  logic      out_of_grid;
  logic      below_ok;
  logic      side_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign capture_in = in_valid && !in_stall;

  // A size of zero acts as one; a size above the maximum acts as the maximum.
  always_comb begin
    if (grid_width == '0) begin
      w_eff = SIZE_W'(1);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_RESET;
      grid_height <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bounds checks. The row below and the side column only get used once
  // these checks have passed, so eight-bit sums are enough for them.
  assign out_of_grid = ({1'b0, op_col} >= w_eff) || ({1'b0, op_row} >= h_eff);
  assign below_ok    = ({1'b0, op_row} + SIZE_W'(1)) < h_eff;
  assign side_ok     = op_right ? (({1'b0, op_col} + SIZE_W'(1)) < w_eff)
                                : (op_col != '0);
  assign row_below   = op_row + COORD_W'(1);
  assign col_side    = op_right ? (op_col + COORD_W'(1)) : (op_col - COORD_W'(1));

  // The shared address unit: one row-times-MAX_WIDTH plus column for every access.
  always_comb begin
    case (addr_sel)
      ADDR_HERE: begin
        sel_row = op_row;
        sel_col = op_col;
      end
      ADDR_BELOW: begin
        sel_row = row_below;
        sel_col = op_col;
      end
      ADDR_SIDE: begin
        sel_row = row_below;
        sel_col = col_side;
      end
      default: begin
        sel_row = op_row;
        sel_col = op_col;
      end
    endcase
  end

  assign gen_addr = ADDR_W'(sel_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sel_col);
  assign mem_addr = clearing ? clr_addr : gen_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    rd_data <= grid_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Next state, memory control and working result.
  always_comb begin
    state_next     = state;
    mem_we         = 1'b0;
    mem_wdata      = CELL_EMPTY;
    addr_sel       = ADDR_HERE;
    clearing       = 1'b0;
    load_out       = 1'b0;
    old_cell_next  = old_cell;
    move_code_next = move_code;
    err_flag_next  = err_flag;
    case (state)
      S_CLEAR: begin
        clearing = 1'b1;
        mem_we   = 1'b1;
        if (clr_addr == ADDR_W'(GRID_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (capture_in) begin
          old_cell_next  = CELL_EMPTY;
          move_code_next = MOVE_STAY;
          err_flag_next  = 1'b0;
          state_next     = S_LOOK;
        end
      end
      S_LOOK: begin
        // The read of the addressed cell is issued here in any case.
        if (out_of_grid) begin
          err_flag_next = 1'b1;
          state_next    = S_DONE;
        end else begin
          state_next = S_HERE;
        end
      end
      S_HERE: begin
        old_cell_next = rd_data;
        if (op_kind == KIND_WRITE) begin
          mem_we     = 1'b1;
          mem_wdata  = op_new;
          state_next = S_DONE;
        end else if (op_kind == KIND_STEP && rd_data == CELL_SAND && below_ok) begin
          addr_sel   = ADDR_BELOW;
          state_next = S_BELOW;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BELOW: begin
        if (rd_data == CELL_EMPTY) begin
          addr_sel       = ADDR_BELOW;
          mem_we         = 1'b1;
          mem_wdata      = CELL_SAND;
          move_code_next = MOVE_FALL;
          state_next     = S_VACATE;
        end else if (side_ok) begin
          addr_sel   = ADDR_SIDE;
          state_next = S_SIDE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SIDE: begin
        if (rd_data == CELL_EMPTY) begin
          addr_sel       = ADDR_SIDE;
          mem_we         = 1'b1;
          mem_wdata      = CELL_SAND;
          move_code_next = MOVE_SLIDE;
          state_next     = S_VACATE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_VACATE: begin
        mem_we     = 1'b1;
        mem_wdata  = CELL_EMPTY;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (capture_in) begin
      op_kind  <= kind;
      op_col   <= col;
      op_row   <= row;
      op_new   <= new_cell;
      op_right <= go_right;
    end
    old_cell  <= old_cell_next;
    move_code <= move_code_next;
    err_flag  <= err_flag_next;
  end

  // Output register. An out-of-grid result carries zeros besides the flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cell_read   <= old_cell;
      color       <= err_flag ? '0 : type_rgb(old_cell);
      moved       <= move_code;
      coord_error <= err_flag;
    end
  end

endmodule

>>> rtl/fsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling-sand cell step checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module fsc_checker
  import fsc_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   out_valid,
  input logic   out_stall,
  input cell_t  cell_read,
  input rgb_t   color,
  input move_t  moved,
  input logic   coord_error
);

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An out-of-grid result carries nothing but the flag.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && coord_error |-> cell_read == CELL_EMPTY && color == '0 &&
                                 moved == MOVE_STAY)
    else $error("out-of-grid result has nonzero fields");

  // Only sand inside the grid ever moves.
  a_move_sand: assert property (@(posedge clk) disable iff (rst)
    out_valid && moved != MOVE_STAY |-> cell_read == CELL_SAND && !coord_error)
    else $error("move reported for a non-sand cell");

  // The color follows the cell type.
  a_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && !coord_error |-> color == type_rgb(cell_read))
    else $error("color does not match cell type");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_read) && $stable(color) &&
                               $stable(moved) && $stable(coord_error))
    else $error("stalled result changed");

endmodule

bind falling_sand_cell_step_core fsc_checker u_fsc_checker (.*);
